// ===== design/cipm_pkg.sv =====
// Shared constants, types and state encoding for the complex inner product magnitude block.
`timescale 1ns / 1ps

package cipm_pkg;

    localparam int LOG2_LENGTH_DEF  = 10;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int FRAC_BITS        = 14;
    localparam int OUT_W            = 24;
    localparam int SQ_W             = 2 * OUT_W;
    localparam int QUEUE_DEPTH      = 4;
    localparam int PTR_W            = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);
    localparam int ITER_W           = $clog2(OUT_W);

    typedef struct packed {
        logic             sat;
        logic [OUT_W-1:0] mag_re;
        logic [OUT_W-1:0] mag_im;
    } entry_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              empty;
    } queue_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SUM,
        ST_ROOT,
        ST_WAIT
    } back_state_t;

endpackage

// ===== design/cipm_front.sv =====
// Front end: multiply, accumulate, scale and clip, push finished sums to the queue.
`timescale 1ns / 1ps

module cipm_front #(
    parameter int LOG2_LENGTH  = cipm_pkg::LOG2_LENGTH_DEF,
    parameter int SAMPLE_WIDTH = cipm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [((4*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
    input  logic                        s_tlast,
    input  cipm_pkg::queue_stat_t       qstat,
    output logic                        push,
    output cipm_pkg::entry_t            push_entry
);

    localparam int SW      = SAMPLE_WIDTH;
    localparam int PW      = 2 * SW;
    localparam int ACC_RAW = 2 * SW + LOG2_LENGTH + 2;
    localparam int ACC_W   = (ACC_RAW > 62) ? 62 : ACC_RAW;
    localparam int OUT_W   = cipm_pkg::OUT_W;
    localparam int EXT_W   = (ACC_W > OUT_W + 2) ? ACC_W : OUT_W + 2;
    localparam int CRED_W  = cipm_pkg::QCNT_W + 2;

    localparam logic signed [EXT_W-1:0] OUT_MAX_E =
        {{(EXT_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [EXT_W-1:0] OUT_MIN_E =
        {{(EXT_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

    typedef struct packed {
        logic             sat;
        logic [OUT_W-1:0] mag;
    } clip_t;

    function automatic clip_t clip_mag(input logic signed [ACC_W-1:0] acc);
        logic signed [EXT_W-1:0] ext;
        logic signed [EXT_W-1:0] q;
        clip_t                   r;
        ext = EXT_W'(acc);
        q   = ext >>> cipm_pkg::FRAC_BITS;
        if (q > OUT_MAX_E) begin
            r.sat = 1'b1;
            r.mag = OUT_W'(OUT_MAX_E);
        end else if (q < OUT_MIN_E) begin
            r.sat = 1'b1;
            r.mag = OUT_W'(-OUT_MIN_E);
        end else if (q < 0) begin
            r.sat = 1'b0;
            r.mag = OUT_W'(-q);
        end else begin
            r.sat = 1'b0;
            r.mag = OUT_W'(q);
        end
        return r;
    endfunction

    logic signed [SW-1:0]    a_re, a_im, b_re, b_im;
    logic                    accept;
    logic [CRED_W-1:0]       need;

    logic                    st1_valid_reg, st1_last_reg;
    logic signed [PW-1:0]    p_rr_reg, p_ii_reg, p_ir_reg, p_ri_reg;

    logic signed [ACC_W-1:0] sum_real_reg, sum_imag_reg;
    logic signed [ACC_W-1:0] sum_real_next, sum_imag_next;
    logic                    fin_valid_reg;
    logic signed [ACC_W-1:0] fin_re_reg, fin_im_reg;

    clip_t                   clip_re, clip_im;

    assign a_re = signed'(s_tdata[SW-1:0]);
    assign a_im = signed'(s_tdata[2*SW-1:SW]);
    assign b_re = signed'(s_tdata[3*SW-1:2*SW]);
    assign b_im = signed'(s_tdata[4*SW-1:3*SW]);

    // reserve a queue slot for every frame end still in flight plus this word
    assign need = CRED_W'(qstat.count) + CRED_W'(st1_last_reg)
                + CRED_W'(fin_valid_reg) + CRED_W'(1);
    assign s_tready = (need <= CRED_W'(cipm_pkg::QUEUE_DEPTH));
    assign accept   = s_tvalid & s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st1_last_reg  <= 1'b0;
        end else begin
            st1_valid_reg <= accept;
            st1_last_reg  <= accept & s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        p_rr_reg <= a_re * b_re;
        p_ii_reg <= a_im * b_im;
        p_ir_reg <= a_im * b_re;
        p_ri_reg <= a_re * b_im;
    end

    assign sum_real_next = sum_real_reg + ACC_W'(p_rr_reg) + ACC_W'(p_ii_reg);
    assign sum_imag_next = sum_imag_reg + ACC_W'(p_ir_reg) - ACC_W'(p_ri_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_real_reg  <= '0;
            sum_imag_reg  <= '0;
            fin_valid_reg <= 1'b0;
        end else begin
            fin_valid_reg <= st1_valid_reg & st1_last_reg;
            if (st1_valid_reg) begin
                if (st1_last_reg) begin
                    sum_real_reg <= '0;
                    sum_imag_reg <= '0;
                end else begin
                    sum_real_reg <= sum_real_next;
                    sum_imag_reg <= sum_imag_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (st1_valid_reg && st1_last_reg) begin
            fin_re_reg <= sum_real_next;
            fin_im_reg <= sum_imag_next;
        end
    end

    assign clip_re = clip_mag(fin_re_reg);
    assign clip_im = clip_mag(fin_im_reg);

    assign push              = fin_valid_reg;
    assign push_entry.sat    = clip_re.sat | clip_im.sat;
    assign push_entry.mag_re = clip_re.mag;
    assign push_entry.mag_im = clip_im.mag;

endmodule

// ===== design/cipm_queue.sv =====
// Short queue of clipped sum magnitudes between front and back end.
`timescale 1ns / 1ps

module cipm_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  cipm_pkg::entry_t      push_entry,
    input  logic                  pop,
    output cipm_pkg::entry_t      head,
    output cipm_pkg::queue_stat_t qstat
);

    localparam int DEPTH  = cipm_pkg::QUEUE_DEPTH;
    localparam int PTR_W  = cipm_pkg::PTR_W;
    localparam int QCNT_W = cipm_pkg::QCNT_W;

    cipm_pkg::entry_t  mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
    assign count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head        = mem_reg[rd_ptr_reg];
    assign qstat.count = count_reg;
    assign qstat.empty = (count_reg == '0);

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg < QCNT_W'(DEPTH) || pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("queue read while empty");

endmodule

// ===== design/cipm_back.sv =====
// Back end: square, add and bit-serial floor square root, then the output register.
`timescale 1ns / 1ps

module cipm_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  cipm_pkg::queue_stat_t             qstat,
    input  cipm_pkg::entry_t                  head,
    output logic                              pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [cipm_pkg::OUT_W-1:0]        m_tdata,
    output logic                              m_tuser
);

    localparam int OUT_W  = cipm_pkg::OUT_W;
    localparam int SQ_W   = cipm_pkg::SQ_W;
    localparam int ITER_W = cipm_pkg::ITER_W;

    cipm_pkg::back_state_t state_reg, state_next;

    logic              sq_load, rad_load, root_step, iter_clear, out_load, out_free;
    logic              sat_reg;
    logic [OUT_W-1:0]  mag_re_reg, mag_im_reg;
    logic [SQ_W-1:0]   sq_re_reg, sq_im_reg, rad_reg;
    logic [OUT_W:0]    rem_reg;
    logic [OUT_W-1:0]  root_reg;
    logic [ITER_W-1:0] iter_reg;
    logic [OUT_W+2:0]  trial_rem, trial;
    logic              out_valid_reg, out_sat_reg;
    logic [OUT_W-1:0]  out_mag_reg;

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cipm_pkg::ST_IDLE: begin
                if (!qstat.empty) begin
                    state_next = cipm_pkg::ST_SQUARE;
                end
            end
            cipm_pkg::ST_SQUARE: state_next = cipm_pkg::ST_SUM;
            cipm_pkg::ST_SUM:    state_next = cipm_pkg::ST_ROOT;
            cipm_pkg::ST_ROOT: begin
                if (iter_reg == ITER_W'(OUT_W - 1)) begin
                    state_next = cipm_pkg::ST_WAIT;
                end
            end
            cipm_pkg::ST_WAIT: begin
                if (out_free) begin
                    state_next = cipm_pkg::ST_IDLE;
                end
            end
            default: state_next = cipm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        pop        = 1'b0;
        sq_load    = 1'b0;
        rad_load   = 1'b0;
        iter_clear = 1'b0;
        root_step  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            cipm_pkg::ST_IDLE:   pop = !qstat.empty;
            cipm_pkg::ST_SQUARE: sq_load = 1'b1;
            cipm_pkg::ST_SUM: begin
                rad_load   = 1'b1;
                iter_clear = 1'b1;
            end
            cipm_pkg::ST_ROOT:   root_step = 1'b1;
            cipm_pkg::ST_WAIT:   out_load = out_free;
            default: begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= cipm_pkg::ST_IDLE;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (iter_clear) begin
                iter_reg <= '0;
            end else if (root_step) begin
                iter_reg <= iter_reg + ITER_W'(1);
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign trial_rem = {rem_reg, rad_reg[SQ_W-1:SQ_W-2]};
    assign trial     = {1'b0, root_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (pop) begin
            sat_reg    <= head.sat;
            mag_re_reg <= head.mag_re;
            mag_im_reg <= head.mag_im;
        end
        if (sq_load) begin
            sq_re_reg <= mag_re_reg * mag_re_reg;
            sq_im_reg <= mag_im_reg * mag_im_reg;
        end
        if (rad_load) begin
            rad_reg  <= sq_re_reg + sq_im_reg;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (root_step) begin
            rad_reg <= {rad_reg[SQ_W-3:0], 2'b00};
            if (trial_rem >= trial) begin
                rem_reg  <= (OUT_W+1)'(trial_rem - trial);
                root_reg <= {root_reg[OUT_W-2:0], 1'b1};
            end else begin
                rem_reg  <= (OUT_W+1)'(trial_rem);
                root_reg <= {root_reg[OUT_W-2:0], 1'b0};
            end
        end
        if (out_load) begin
            out_mag_reg <= root_reg;
            out_sat_reg <= sat_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_mag_reg;
    assign m_tuser  = out_sat_reg;

    a_square_after_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> state_reg == cipm_pkg::ST_SQUARE)
        else $error("square stage not entered after queue read");

    a_result_from_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg) == cipm_pkg::ST_WAIT)
        else $error("result word loaded outside root completion");

endmodule

// ===== design/complex_inner_product_magnitude.sv =====
// Frame sums pass the product and sum registers, the queue, the square, sum, root and wait
// states, then the output register. One input word per cycle while s_tready is high; the
// back end finishes each result's 24-step root before it pops the next. The front stalls
// s_tready only when frame ends arrive faster than the back drains the four-entry queue.
// Reset (aresetn low, synchronous) clears both sums, the queue and all valid flags; no
// clearing pass is needed. Top level of the complex inner product magnitude block.
`timescale 1ns / 1ps

module complex_inner_product_magnitude #(
    parameter int LOG2_LENGTH  = cipm_pkg::LOG2_LENGTH_DEF,
    parameter int SAMPLE_WIDTH = cipm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // a_re, a_im, b_re, b_im from the lowest bit up, zero padding above
    input  logic [((4*SAMPLE_WIDTH+7)/8)*8-1:0]  s_tdata,
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // fidelity_mag
    output logic [cipm_pkg::OUT_W-1:0]           m_tdata,
    // saturated
    output logic                                 m_tuser
);

    logic                  push, pop;
    cipm_pkg::entry_t      push_entry, head;
    cipm_pkg::queue_stat_t qstat;

    cipm_front #(
        .LOG2_LENGTH (LOG2_LENGTH),
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .qstat     (qstat),
        .push      (push),
        .push_entry(push_entry)
    );

    cipm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_entry(push_entry),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat)
    );

    cipm_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .qstat   (qstat),
        .head    (head),
        .pop     (pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule
